FILE: rtl/core/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants of the sprite frame sequencer
// Widths, register map, the configuration struct and the control structs between sequencer and divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

    localparam int FRAME_BITS  = 8;
    localparam int TIME_BITS   = 16;
    localparam int REPEAT_BITS = 8;
    localparam int ELAPSED_W   = TIME_BITS + 1;
    localparam int NF_W        = FRAME_BITS + 1;
    localparam int PROD_W      = ELAPSED_W + NF_W;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_START_FRAME     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_END_FRAME       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ANIM_DURATION   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_REPEATS = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PING_PONG       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LOOP_FOREVER    = 3'd5;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic [FRAME_BITS-1:0]  start_frame;
        logic [FRAME_BITS-1:0]  end_frame;
        logic [TIME_BITS-1:0]   anim_duration;
        logic [REPEAT_BITS-1:0] initial_repeats;
        logic                   ping_pong;
        logic                   loop_forever;
    } cfg_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sprite_frame_sequencer_top.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_top: animation frame index sequencer
// Accumulates tick time, scales it to a frame step through a serial divider
// and steps the frame index forward, backward or ping-pong with repeats.
// ----------------------------------------------------------------------------
//  channel   ports                                     direction
//  cfg       psel penable pwrite paddr pwdata prdata   in / out (APB)
//            pready
//  input     s_valid s_ready s_op s_delta_time         in
//  result    m_valid m_ready m_frame_index m_running   out
//            m_reversed m_repeats_left
//
//  A tick on a running animation passes through multiply, divider launch,
//  PROD_W (26) divider steps, divider done and finish before its result shows;
//  the divider steps make up most of that path.
//  A start command or an idle tick goes from idle straight to the finish step.
//  One transaction is in flight at a time; s_ready is low until its result is
//  issued, and a second result holds in the finish step until m_ready frees it.
//  Synchronous active-low reset clears state and m_valid and resets the configuration (duration to 1).
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_frame_sequencer_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sfs_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [sfs_pkg::DATA_W-1:0]      pwdata,
    output logic      [sfs_pkg::DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_op,
    input  wire logic [sfs_pkg::TIME_BITS-1:0]   s_delta_time,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [sfs_pkg::FRAME_BITS-1:0]  m_frame_index,
    output logic                                 m_running,
    output logic                                 m_reversed,
    output logic      [sfs_pkg::REPEAT_BITS-1:0] m_repeats_left
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_LAUNCH = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    sfs_pkg::cfg_t      cfg;
    sfs_pkg::div_ctrl_t div_ctrl;
    sfs_pkg::div_stat_t div_stat;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [sfs_pkg::ELAPSED_W-1:0]   elapsed_reg;
    logic [sfs_pkg::ELAPSED_W-1:0]   elapsed_next;
    logic [sfs_pkg::FRAME_BITS-1:0]  frame_reg;
    logic [sfs_pkg::FRAME_BITS-1:0]  frame_next;
    logic                            active_reg;
    logic                            active_next;
    logic                            backward_reg;
    logic                            backward_next;
    logic [sfs_pkg::REPEAT_BITS-1:0] repeat_reg;
    logic [sfs_pkg::REPEAT_BITS-1:0] repeat_next;

    logic                            op_reg;
    logic [sfs_pkg::NF_W-1:0]        nf_reg;
    logic [sfs_pkg::PROD_W-1:0]      prod_reg;
    logic [sfs_pkg::PROD_W-1:0]      quotient;

    logic                            m_valid_reg;
    logic [sfs_pkg::FRAME_BITS-1:0]  m_frame_reg;
    logic                            m_running_reg;
    logic                            m_reversed_reg;
    logic [sfs_pkg::REPEAT_BITS-1:0] m_repeats_reg;

    logic                            in_accept;
    logic                            out_free;
    logic                            fin_fire;
    logic                            fwd_order;
    logic [sfs_pkg::FRAME_BITS-1:0]  lo_frame;
    logic [sfs_pkg::FRAME_BITS-1:0]  span;
    logic [sfs_pkg::FRAME_BITS-1:0]  nf_base;
    logic [sfs_pkg::TIME_BITS-1:0]   dur;
    logic [sfs_pkg::FRAME_BITS-1:0]  step_sat;
    logic [sfs_pkg::FRAME_BITS-1:0]  frame_calc;
    logic                            pass_done;
    logic                            bw_flip;

    sfs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (prod_reg),
        .divisor  (dur),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign fin_fire  = (state_reg == ST_FIN) && out_free;

    assign m_valid        = m_valid_reg;
    assign m_frame_index  = m_frame_reg;
    assign m_running      = m_running_reg;
    assign m_reversed     = m_reversed_reg;
    assign m_repeats_left = m_repeats_reg;

    assign div_ctrl.start = (state_reg == ST_LAUNCH);

    assign fwd_order = cfg.start_frame <= cfg.end_frame;
    assign lo_frame  = fwd_order ? cfg.start_frame : cfg.end_frame;
    assign span      = fwd_order ? (cfg.end_frame - cfg.start_frame)
                                 : (cfg.start_frame - cfg.end_frame);
    assign nf_base   = (lo_frame > span) ? lo_frame : span;
    assign dur       = (cfg.anim_duration == '0) ? sfs_pkg::TIME_BITS'(1)
                                                 : cfg.anim_duration;

    assign step_sat  = (quotient > sfs_pkg::PROD_W'(span)) ? span
                                                          : quotient[sfs_pkg::FRAME_BITS-1:0];
    assign pass_done = elapsed_reg >= sfs_pkg::ELAPSED_W'(dur);
    assign bw_flip   = cfg.ping_pong ? !backward_reg : backward_reg;

    always_comb begin
        if (backward_reg) begin
            frame_calc = fwd_order ? (cfg.end_frame - step_sat) : cfg.start_frame;
        end else begin
            frame_calc = lo_frame + step_sat;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_op == sfs_pkg::OP_TICK && active_reg) begin
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        elapsed_next  = elapsed_reg;
        frame_next    = frame_reg;
        active_next   = active_reg;
        backward_next = backward_reg;
        repeat_next   = repeat_reg;
        if (in_accept && s_op == sfs_pkg::OP_TICK && active_reg) begin
            elapsed_next = elapsed_reg + sfs_pkg::ELAPSED_W'(s_delta_time);
        end
        if (fin_fire) begin
            if (op_reg == sfs_pkg::OP_START) begin
                elapsed_next  = '0;
                active_next   = 1'b1;
                backward_next = 1'b0;
                repeat_next   = cfg.initial_repeats;
                frame_next    = cfg.start_frame;
            end else if (active_reg) begin
                frame_next = frame_calc;
                if (pass_done) begin
                    elapsed_next = '0;
                    if (!cfg.loop_forever && repeat_reg == '0) begin
                        active_next = 1'b0;
                    end else begin
                        if (!cfg.loop_forever) begin
                            repeat_next = repeat_reg - sfs_pkg::REPEAT_BITS'(1);
                        end
                        backward_next = bw_flip;
                        frame_next    = bw_flip ? cfg.end_frame : cfg.start_frame;
                    end
                end
            end else if (repeat_reg != '0 || cfg.loop_forever) begin
                active_next  = 1'b1;
                elapsed_next = '0;
                if (!cfg.loop_forever) begin
                    repeat_next = repeat_reg - sfs_pkg::REPEAT_BITS'(1);
                end
                backward_next = bw_flip;
                frame_next    = bw_flip ? cfg.end_frame : cfg.start_frame;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            elapsed_reg  <= '0;
            frame_reg    <= '0;
            active_reg   <= 1'b0;
            backward_reg <= 1'b0;
            repeat_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            elapsed_reg  <= elapsed_next;
            frame_reg    <= frame_next;
            active_reg   <= active_next;
            backward_reg <= backward_next;
            repeat_reg   <= repeat_next;
            if (fin_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg <= s_op;
            nf_reg <= {1'b0, nf_base} + sfs_pkg::NF_W'(1);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= sfs_pkg::PROD_W'(elapsed_reg) * sfs_pkg::PROD_W'(nf_reg);
        end
        if (fin_fire) begin
            m_frame_reg    <= frame_next;
            m_running_reg  <= active_next;
            m_reversed_reg <= backward_next;
            m_repeats_reg  <= repeat_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sfs_regs.sv
// ----------------------------------------------------------------------------
// sfs_regs: configuration register file
// APB-style slave holding the animation range, duration and repeat controls.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [sfs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [sfs_pkg::DATA_W-1:0] pwdata,
    output logic      [sfs_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output sfs_pkg::cfg_t                   cfg
);

    sfs_pkg::cfg_t                    cfg_reg;
    sfs_pkg::cfg_t                    cfg_next;
    logic                             wr_en;
    logic [sfs_pkg::REG_IDX_W-1:0]    idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[sfs_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                sfs_pkg::REG_START_FRAME: begin
                    cfg_next.start_frame = pwdata[sfs_pkg::FRAME_BITS-1:0];
                end
                sfs_pkg::REG_END_FRAME: begin
                    cfg_next.end_frame = pwdata[sfs_pkg::FRAME_BITS-1:0];
                end
                sfs_pkg::REG_ANIM_DURATION: begin
                    cfg_next.anim_duration = pwdata[sfs_pkg::TIME_BITS-1:0];
                end
                sfs_pkg::REG_INITIAL_REPEATS: begin
                    cfg_next.initial_repeats = pwdata[sfs_pkg::REPEAT_BITS-1:0];
                end
                sfs_pkg::REG_PING_PONG: begin
                    cfg_next.ping_pong = pwdata[0];
                end
                sfs_pkg::REG_LOOP_FOREVER: begin
                    cfg_next.loop_forever = pwdata[0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_frame     <= '0;
            cfg_reg.end_frame       <= '0;
            cfg_reg.anim_duration   <= sfs_pkg::TIME_BITS'(1);
            cfg_reg.initial_repeats <= '0;
            cfg_reg.ping_pong       <= 1'b0;
            cfg_reg.loop_forever    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            sfs_pkg::REG_START_FRAME: begin
                prdata = sfs_pkg::DATA_W'(cfg_reg.start_frame);
            end
            sfs_pkg::REG_END_FRAME: begin
                prdata = sfs_pkg::DATA_W'(cfg_reg.end_frame);
            end
            sfs_pkg::REG_ANIM_DURATION: begin
                prdata = sfs_pkg::DATA_W'(cfg_reg.anim_duration);
            end
            sfs_pkg::REG_INITIAL_REPEATS: begin
                prdata = sfs_pkg::DATA_W'(cfg_reg.initial_repeats);
            end
            sfs_pkg::REG_PING_PONG: begin
                prdata = sfs_pkg::DATA_W'(cfg_reg.ping_pong);
            end
            sfs_pkg::REG_LOOP_FOREVER: begin
                prdata = sfs_pkg::DATA_W'(cfg_reg.loop_forever);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/sfs_divider.sv
// ----------------------------------------------------------------------------
// sfs_divider: serial restoring divider
// One quotient bit per cycle; divides the scaled elapsed time by the duration.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  sfs_pkg::div_ctrl_t                 ctrl,
    input  wire logic [sfs_pkg::PROD_W-1:0]    dividend,
    input  wire logic [sfs_pkg::TIME_BITS-1:0] divisor,
    output sfs_pkg::div_stat_t                 stat,
    output logic      [sfs_pkg::PROD_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(sfs_pkg::PROD_W + 1);

    logic [sfs_pkg::PROD_W-1:0]    quo_reg;
    logic [sfs_pkg::PROD_W-1:0]    quo_next;
    logic [sfs_pkg::TIME_BITS-1:0] rem_reg;
    logic [sfs_pkg::TIME_BITS-1:0] rem_next;
    logic [sfs_pkg::TIME_BITS-1:0] dsr_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [sfs_pkg::TIME_BITS:0]   trial;
    logic [sfs_pkg::TIME_BITS:0]   diff;
    logic                          fits;

    assign trial    = {rem_reg, quo_reg[sfs_pkg::PROD_W-1]};
    assign diff     = trial - {1'b0, dsr_reg};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign rem_next = fits ? diff[sfs_pkg::TIME_BITS-1:0] : trial[sfs_pkg::TIME_BITS-1:0];
    assign quo_next = {quo_reg[sfs_pkg::PROD_W-2:0], fits};

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(sfs_pkg::PROD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker: port-level checks of the sprite frame sequencer
// Watches the transaction handshakes of the top level; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [sfs_pkg::FRAME_BITS-1:0] m_frame_index
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result pending or input blocked after reset");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in flight");

    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result issued without returning to idle");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_index))
        else $error("stalled result dropped or changed");

endmodule

bind sprite_frame_sequencer_top sfs_checker u_sfs_checker (.*);

`default_nettype wire
